// ===== rtl/wpfm_pkg.sv =====
`timescale 1ns / 1ps

package wpfm_pkg;

    localparam int PATTERN_MAX_DEF   = 32;
    localparam int POSITION_BITS_DEF = 32;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 6;
    localparam int POS_OUT_W = 32;
    localparam int PAT_WORDS = 4;
    localparam int PAT_W     = PAT_WORDS * CFG_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 3'd4;

    localparam logic [LEN_W-1:0] LEN_RESET = 6'd1;

    localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LOWB   = 8'h62;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic                 found;
        logic [POS_OUT_W-1:0] match_position;
    } t_out_word;

    function automatic logic byte_matches(input logic [BYTE_W-1:0] p,
                                          input logic [BYTE_W-1:0] t);
        logic r;
        if (p == CH_CARET) begin
            r = (t == CH_HASH) || (t == CH_PLUS);
        end else if (p == CH_UNDER) begin
            r = (t == CH_LOWB) || (t == CH_MINUS);
        end else begin
            r = (p == t);
        end
        return r;
    endfunction

endpackage

// ===== rtl/wpfm_cfg_regs.sv =====
`timescale 1ns / 1ps

module wpfm_cfg_regs #(
    parameter int PATTERN_MAX = wpfm_pkg::PATTERN_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [wpfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpfm_pkg::CFG_W-1:0]      i_cfg_data,
    output logic [wpfm_pkg::PAT_W-1:0]      o_pattern,
    output logic [wpfm_pkg::LEN_W-1:0]      o_eff_len
);

    logic [wpfm_pkg::PAT_WORDS-1:0][wpfm_pkg::CFG_W-1:0] r_pattern;
    logic [wpfm_pkg::LEN_W-1:0]                          r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= wpfm_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wpfm_pkg::CFG_PAT0: r_pattern[0] <= i_cfg_data;
                wpfm_pkg::CFG_PAT1: r_pattern[1] <= i_cfg_data;
                wpfm_pkg::CFG_PAT2: r_pattern[2] <= i_cfg_data;
                wpfm_pkg::CFG_PAT3: r_pattern[3] <= i_cfg_data;
                wpfm_pkg::CFG_LEN:  r_length     <= i_cfg_data[wpfm_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_pattern = r_pattern;

    // Zero acts as one; anything past the window depth is clamped to it.
    always_comb begin
        if (r_length == '0) begin
            o_eff_len = wpfm_pkg::LEN_W'(1);
        end else if (r_length > wpfm_pkg::LEN_W'(PATTERN_MAX)) begin
            o_eff_len = wpfm_pkg::LEN_W'(PATTERN_MAX);
        end else begin
            o_eff_len = r_length;
        end
    end

endmodule

// ===== rtl/wpfm_match.sv =====
`timescale 1ns / 1ps

module wpfm_match #(
    parameter int PATTERN_MAX   = wpfm_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = wpfm_pkg::POSITION_BITS_DEF
) (
    input  logic [PATTERN_MAX-1:0][wpfm_pkg::BYTE_W-1:0] i_window,
    input  logic [wpfm_pkg::PAT_W-1:0]                   i_pattern,
    input  logic [wpfm_pkg::LEN_W-1:0]                   i_eff_len,
    input  logic [POSITION_BITS-1:0]                     i_count,
    input  logic                                         i_reported,
    output logic                                         o_hit,
    output logic [wpfm_pkg::POS_OUT_W-1:0]               o_position
);

    localparam int WIN_IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [PATTERN_MAX-1:0]   ok;
    logic [POSITION_BITS-1:0] len_ext;
    logic [POSITION_BITS-1:0] start;

    // Pattern byte i lines up with the window entry len-1-i (entry 0 is newest).
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
        logic [wpfm_pkg::LEN_W-1:0]  tap;
        logic [wpfm_pkg::BYTE_W-1:0] pat_b;
        assign tap   = i_eff_len - wpfm_pkg::LEN_W'(i + 1);
        assign pat_b = i_pattern[i*wpfm_pkg::BYTE_W +: wpfm_pkg::BYTE_W];
        assign ok[i] = (wpfm_pkg::LEN_W'(i) >= i_eff_len) ||
                       wpfm_pkg::byte_matches(pat_b, i_window[tap[WIN_IDX_W-1:0]]);
    end

    assign len_ext    = POSITION_BITS'(i_eff_len);
    assign start      = i_count - len_ext;
    assign o_hit      = !i_reported && (i_count >= len_ext) && (&ok);
    assign o_position = wpfm_pkg::POS_OUT_W'(start);

endmodule

// ===== rtl/wildcard_pattern_first_match.sv =====
`timescale 1ns / 1ps

// Wildcard pattern first-match detector.
// Text words (one byte plus an end-of-text flag) enter on the input channel
// (i_in_valid / o_in_stall); result words leave on the output channel
// (o_out_valid / i_out_stall). A word moves when valid is high and stall low.
// Each text gives at most one result: found=1 with the start offset on the
// byte that completes the first match, or found=0 on its final byte when
// no match occurred. The following text starts from a clean state.
// Configuration is written through i_cfg_valid / o_cfg_ready, index and data.
// The user must write it only while the block is idle; the block does not
// enforce this. o_cfg_ready is always high. A byte enters the window
// register when it is accepted, and its result moves from there into the
// output register when the stage advances. One byte is taken every cycle
// while o_in_stall is low: all window positions are compared in parallel.
// Reset clears the pattern, sets the length to one and empties the pipeline.
// When the receiver stalls, the pending result holds in the output register;
// the next byte is still taken, and input stall rises only when that byte
// also has a result to deliver.
module wildcard_pattern_first_match #(
    parameter int PATTERN_MAX   = wpfm_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = wpfm_pkg::POSITION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  wpfm_pkg::t_in_word             i_in_word,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output wpfm_pkg::t_out_word            o_out_word,
    input  logic                           i_out_stall,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wpfm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wpfm_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [wpfm_pkg::PAT_W-1:0] pattern;
    logic [wpfm_pkg::LEN_W-1:0] eff_len;

    logic [PATTERN_MAX-1:0][wpfm_pkg::BYTE_W-1:0] r_window, n_window;
    logic [POSITION_BITS-1:0]                     r_count, n_count, count_base;
    logic r_stg_valid, n_stg_valid;
    logic r_stg_last;
    logic r_reported, n_reported;
    logic r_out_valid;
    wpfm_pkg::t_out_word r_out_word;

    logic                           hit;
    logic [wpfm_pkg::POS_OUT_W-1:0] position;
    logic accept_in, res_valid, out_free, advance;

    assign o_cfg_ready = 1'b1;

    wpfm_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pattern   (pattern),
        .o_eff_len   (eff_len)
    );

    wpfm_match #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .i_window   (r_window),
        .i_pattern  (pattern),
        .i_eff_len  (eff_len),
        .i_count    (r_count),
        .i_reported (r_reported),
        .o_hit      (hit),
        .o_position (position)
    );

    assign res_valid  = r_stg_valid && (hit || (r_stg_last && !r_reported));
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_stg_valid && (!res_valid || out_free);
    assign o_in_stall = r_stg_valid && !advance;
    assign accept_in  = i_in_valid && !o_in_stall;

    // Old window entries need no clearing: the byte count keeps the compare
    // from reaching bytes of an earlier text.
    always_comb begin
        n_window = r_window;
        if (accept_in) begin
            for (int k = PATTERN_MAX - 1; k > 0; k--) begin
                n_window[k] = r_window[k-1];
            end
            n_window[0] = i_in_word.text_byte;
        end
    end

    always_comb begin
        count_base = (advance && r_stg_last) ? '0 : r_count;
        n_count    = count_base;
        if (accept_in && !(&count_base)) begin
            n_count = count_base + POSITION_BITS'(1);
        end
    end

    always_comb begin
        n_reported = r_reported;
        if (advance) begin
            n_reported = r_stg_last ? 1'b0 : (r_reported || hit);
        end
    end

    always_comb begin
        n_stg_valid = r_stg_valid;
        if (accept_in) begin
            n_stg_valid = 1'b1;
        end else if (advance) begin
            n_stg_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_stg_valid <= 1'b0;
            r_reported  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_stg_valid <= n_stg_valid;
            r_reported  <= n_reported;
            if (out_free) begin
                r_out_valid <= advance && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        if (accept_in) begin
            r_stg_last <= i_in_word.last_byte;
        end
        if (out_free && advance && res_valid) begin
            r_out_word.found          <= hit;
            r_out_word.match_position <= hit ? position : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/wpfm_checker.sv =====
`timescale 1ns / 1ps

module wpfm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input wpfm_pkg::t_out_word o_out_word,
    input logic                i_out_stall
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("result word changed while stalled");

    // The input side only backs up behind a waiting result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled with no result waiting");

    // A not-found result always carries a zero offset.
    a_nf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.found) |-> (o_out_word.match_position == '0))
        else $error("not-found result with nonzero offset");

endmodule

bind wildcard_pattern_first_match wpfm_checker u_wpfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_word  (o_out_word),
    .i_out_stall (i_out_stall)
);

// ===== verif/tb_wildcard_pattern_first_match.sv =====
`timescale 1ns / 1ps

module tb_wildcard_pattern_first_match;
    import wpfm_pkg::*;

    // Tracks the expected result words of the first-match search and
    // compares them with what the block delivers.
    class first_match_board;
        logic [CFG_W-1:0]  pat_words [PAT_WORDS];
        logic [LEN_W-1:0]  pat_len;
        logic [BYTE_W-1:0] window [32];
        logic [31:0]       seen;
        bit                reported;
        t_out_word         awaited [$];
        int                errors;

        function new();
            foreach (pat_words[i]) pat_words[i] = '0;
            pat_len = LEN_RESET;
            errors  = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[i]) window[i] = '0;
            seen     = '0;
            reported = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx <= CFG_PAT3) begin
                pat_words[idx] = data;
            end else if (idx == CFG_LEN) begin
                pat_len = data[LEN_W-1:0];
            end
        endfunction

        function void note_byte(t_in_word w);
            int unsigned       n;
            bit                hit;
            logic [BYTE_W-1:0] p;
            logic [BYTE_W-1:0] t;
            t_out_word         res;
            n = (pat_len == 0) ? 1 : ((pat_len > 32) ? 32 : pat_len);
            for (int i = 31; i > 0; i--) window[i] = window[i-1];
            window[0] = w.text_byte;
            if (seen != 32'hFFFF_FFFF) seen++;
            if (!reported && seen >= n) begin
                hit = 1'b1;
                for (int i = 0; i < n; i++) begin
                    p = pat_words[i/8][(i%8)*8 +: 8];
                    t = window[n-1-i];
                    case (p)
                        CH_CARET: if (t != CH_HASH && t != CH_PLUS) hit = 1'b0;
                        CH_UNDER: if (t != CH_LOWB && t != CH_MINUS) hit = 1'b0;
                        default:  if (t != p) hit = 1'b0;
                    endcase
                end
                if (hit) begin
                    reported           = 1'b1;
                    res.found          = 1'b1;
                    res.match_position = seen - n;
                    awaited.push_back(res);
                end
            end
            if (w.last_byte) begin
                if (!reported) begin
                    res.found          = 1'b0;
                    res.match_position = '0;
                    awaited.push_back(res);
                end
                clear_text();
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(t_out_word got);
            t_out_word want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected result found=%0b position=%0d",
                                 got.found, got.match_position));
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found)
                report($sformatf("found %0b, expected %0b", got.found, want.found));
            if (got.match_position !== want.match_position)
                report($sformatf("position %0d, expected %0d",
                                 got.match_position, want.match_position));
        endtask
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_in_word             i_in_word   = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_out_word            o_out_word;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_PAT0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    first_match_board  board;
    t_in_word          script [$];
    logic [BYTE_W-1:0] pat_bytes [32];
    bit                no_idle       = 1'b0;
    bit                hold_long_req = 1'b0;

    wildcard_pattern_first_match dut (.*);

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_word);
    end

    function automatic void push_byte(logic [BYTE_W-1:0] b, bit last);
        t_in_word w;
        w.text_byte = b;
        w.last_byte = last;
        script.push_back(w);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_char();
        case ($urandom_range(0, 7))
            0:       return CH_CARET;
            1:       return CH_UNDER;
            2:       return CH_HASH;
            3:       return CH_PLUS;
            4:       return CH_LOWB;
            5:       return CH_MINUS;
            6:       return "a";
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Most texts carry one or two occurrences of the pattern, some of them
    // spoiled in one byte, inside noise drawn mostly from the wildcard bytes.
    function automatic void add_text(int unsigned eff);
        logic [BYTE_W-1:0] body [$];
        int unsigned       kind;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            repeat ($urandom_range(0, 8)) body.push_back(pick_char());
            repeat ($urandom_range(1, 2)) begin
                for (int i = 0; i < eff; i++) begin
                    case (pat_bytes[i])
                        CH_CARET: body.push_back($urandom_range(0, 1) ? CH_HASH : CH_PLUS);
                        CH_UNDER: body.push_back($urandom_range(0, 1) ? CH_LOWB : CH_MINUS);
                        default:  body.push_back(pat_bytes[i]);
                    endcase
                end
                if ($urandom_range(0, 3) == 0)
                    body[body.size() - 1 - $urandom_range(0, eff - 1)] = pick_char();
                repeat ($urandom_range(0, 6)) body.push_back(pick_char());
            end
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 10)) body.push_back(BYTE_W'($urandom_range(0, 255)));
        end else if (kind == 8) begin
            repeat ($urandom_range(1, (eff > 1) ? eff - 1 : 1)) body.push_back(pick_char());
        end else begin
            // Left open: the text goes on in the next texts, or past a new setting.
            repeat ($urandom_range(1, 6)) body.push_back(pick_char());
        end
        for (int i = 0; i < body.size(); i++)
            push_byte(body[i], (kind != 9) && (i == body.size() - 1));
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        board.note_byte(w);
    endtask

    // Registers may only change once nothing is in flight inside the block.
    task automatic settle();
        while (board.awaited.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_script();
        while (script.size() != 0) send_word(script.pop_front());
        i_in_valid <= 1'b0;
        settle();
    endtask

    task automatic program_pattern(input logic [CFG_W-1:0] len_word);
        logic [CFG_W-1:0] data;
        for (int r = CFG_PAT0; r <= CFG_LEN; r++) begin
            if (r == CFG_LEN) begin
                data = len_word;
            end else begin
                for (int k = 0; k < 8; k++) data[k*8 +: 8] = pat_bytes[r*8 + k];
            end
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(r);
            i_cfg_data  <= data;
            do @(posedge i_clk); while (!o_cfg_ready);
            board.set_register(CFG_IDX_W'(r), data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : receiver
        int unsigned hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = no_idle ? 0 : $urandom_range(0, 9);
            if (hold_long_req) begin
                hold          = 200;
                hold_long_req = 1'b0;
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        int unsigned      random_items;
        int unsigned      phase;
        int unsigned      eff;
        logic [LEN_W-1:0] len_sel;
        logic [CFG_W-1:0] len_word;
        board        = new();
        random_items = 0;
        phase        = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: a single zero byte is the pattern.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h05, 1'b1);
        run_script();

        foreach (pat_bytes[i]) pat_bytes[i] = '0;
        pat_bytes[0] = CH_CARET;
        pat_bytes[1] = CH_UNDER;
        pat_bytes[2] = "Z";
        program_pattern(64'd3);
        push_byte("a", 1'b0);
        push_byte(CH_PLUS, 1'b0);
        push_byte(CH_MINUS, 1'b0);
        push_byte("Z", 1'b1);
        push_byte(CH_HASH, 1'b0);
        push_byte(CH_LOWB, 1'b0);
        push_byte("Z", 1'b0);
        push_byte("q", 1'b1);
        push_byte(CH_CARET, 1'b0);
        push_byte(CH_UNDER, 1'b0);
        push_byte("Z", 1'b1);
        push_byte(CH_LOWB, 1'b0);
        push_byte("Z", 1'b1);
        run_script();

        // A length of zero behaves as a length of one.
        pat_bytes[0] = 8'hFF;
        program_pattern(64'd0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hFF, 1'b1);
        run_script();

        // The length shrinks while a text is still open.
        pat_bytes[0] = "A";
        pat_bytes[1] = "B";
        program_pattern(64'd2);
        push_byte("A", 1'b0);
        push_byte("C", 1'b0);
        run_script();
        program_pattern(64'd1);
        push_byte("A", 1'b1);
        run_script();

        while (random_items < 550) begin
            for (int i = 0; i < 32; i++) begin
                pat_bytes[i] = (phase == 2) ? 8'hFF : (phase == 3) ? 8'h00 : pick_char();
            end
            len_word = {$urandom, $urandom};
            if ($urandom_range(0, 1) != 0) len_word[CFG_W-1:LEN_W] = '0;
            case ($urandom_range(0, 9))
                0:       len_sel = '0;
                1:       len_sel = 6'd32;
                2:       len_sel = 6'd63;
                default: len_sel = LEN_W'($urandom_range(1, 6));
            endcase
            if (phase == 0) begin
                len_word = '1;
                len_sel  = '1;
            end else if (phase == 1) begin
                len_sel = 6'd32;
            end
            no_idle = ($urandom_range(0, 3) == 0);
            if (phase == 4) begin
                // Every word carries a result while the receiver holds off.
                pat_bytes[0]  = "p";
                len_sel       = 6'd1;
                no_idle       = 1'b1;
                hold_long_req = 1'b1;
            end
            len_word[LEN_W-1:0] = len_sel;
            eff = (len_sel == 0) ? 1 : ((len_sel > 32) ? 32 : len_sel);
            program_pattern(len_word);
            if (phase == 4) begin
                repeat (30) push_byte("p", 1'b1);
            end else begin
                while (script.size() < 45) add_text(eff);
            end
            random_items += script.size();
            run_script();
            phase++;
        end

        push_byte(pick_char(), 1'b1);
        run_script();
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== wildcard_pattern_first_match.f =====
rtl/wpfm_pkg.sv
rtl/wpfm_cfg_regs.sv
rtl/wpfm_match.sv
rtl/wildcard_pattern_first_match.sv
rtl/wpfm_checker.sv
verif/tb_wildcard_pattern_first_match.sv
